// File: src/tkc_pkg.sv
// token classifier package: result codes, field widths and the keyword table
`timescale 1ns / 1ps
package tkc_pkg;

	localparam int CHAR_W      = 8;
	localparam int KIND_W      = 3;
	localparam int KWCODE_W    = 4;
	localparam int LITERAL_W   = 32;
	localparam int POS_W       = 4;
	localparam int KW_SLOTS    = 16;
	localparam int KW_TEXT_W   = 64;
	localparam logic [POS_W-1:0] POS_SAT = 4'd9;

	localparam logic [KIND_W-1:0] KIND_INT      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_KEYWORD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BADDIGIT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTYHEX = 3'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

	// keyword text right aligned: last character in the low byte
	localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_SLOTS] = '{
		64'("break"), 64'("const"), 64'("continue"), 64'("else"),
		64'("if"), 64'("int"), 64'("return"), 64'("void"), 64'("while"),
		64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
	};

	localparam logic [POS_W-1:0] KW_LEN [KW_SLOTS] = '{
		4'd5, 4'd5, 4'd8, 4'd4, 4'd2, 4'd3, 4'd6, 4'd4, 4'd5,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

endpackage

// File: src/token_literal_keyword_classifier_core.sv
// token classifier top level: integer literal decode and keyword match
// result path: the last character is registered in the input stage, then the result in the output register
// throughput: one character per cycle, but a last character waits in the input stage while the output is held
// a result waits in the output register while the next token's characters come in
// reset: asynchronous, clears the input stage, the output valid and the token state
`timescale 1ns / 1ps
module token_literal_keyword_classifier_core #(
	parameter int VALUE_WIDTH   = 32,
	parameter int KEYWORD_COUNT = 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_stall,
	input  logic [tkc_pkg::CHAR_W-1:0]          char_code,
	input  logic                                last_char,
	output logic                                token_valid,
	input  logic                                token_stall,
	output logic [tkc_pkg::KIND_W-1:0]          token_kind,
	output logic [tkc_pkg::KWCODE_W-1:0]        keyword_code,
	output logic [tkc_pkg::LITERAL_W-1:0]       literal_value
);

	typedef enum logic [2:0] {
		MODE_UNDECIDED = 3'd0,
		MODE_WORD      = 3'd1,
		MODE_DEC       = 3'd2,
		MODE_ZERO      = 3'd3,
		MODE_OCT       = 3'd4,
		MODE_HEX       = 3'd5
	} mode_t;

	logic                              valid_s1;
	logic [tkc_pkg::CHAR_W-1:0]        char_s1;
	logic                              last_s1;

	logic [tkc_pkg::POS_W-1:0]         pos_q, pos_n;
	logic [KEYWORD_COUNT-1:0]          mask_q, mask_n;
	mode_t                             mode_q, mode_n;
	logic [VALUE_WIDTH-1:0]            acc_q, acc_n;
	logic                              bad_q, bad_n;

	logic                              out_free;
	logic                              step;
	logic                              finish;

	logic [3:0]                        digit;
	logic                              is_dec, is_oct, is_hex;
	logic                              take;
	logic                              take_ok;
	logic [VALUE_WIDTH-1:0]            acc_mul;

	logic [tkc_pkg::KIND_W-1:0]        kind_r;
	logic [tkc_pkg::KWCODE_W-1:0]      code_r;
	logic [tkc_pkg::LITERAL_W-1:0]     value_r;

	assign out_free   = !token_valid || !token_stall;
	assign step       = valid_s1 && (!last_s1 || out_free);
	assign finish     = step && last_s1;
	assign char_stall = valid_s1 && !step;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// digit decode
	always_comb begin
		is_dec = (char_s1 >= tkc_pkg::CH_ZERO) && (char_s1 <= tkc_pkg::CH_NINE);
		is_oct = (char_s1 >= tkc_pkg::CH_ZERO) && (char_s1 <= tkc_pkg::CH_SEVEN);
		digit  = char_s1[3:0];
		is_hex = is_dec;
		if ((char_s1 >= tkc_pkg::CH_LA) && (char_s1 <= tkc_pkg::CH_LF)) begin
			is_hex = 1'b1;
			digit  = 4'(char_s1[2:0] + 3'd1) + 4'd8;
		end else if ((char_s1 >= tkc_pkg::CH_UA) && (char_s1 <= tkc_pkg::CH_UF)) begin
			is_hex = 1'b1;
			digit  = 4'(char_s1[2:0] + 3'd1) + 4'd8;
		end
	end

	// next token state
	always_comb begin
		mode_n  = mode_q;
		bad_n   = bad_q;
		take    = 1'b0;
		take_ok = 1'b0;
		acc_mul = acc_q;
		case (mode_q)
			MODE_UNDECIDED: begin
				if (char_s1 == tkc_pkg::CH_ZERO) begin
					mode_n = MODE_ZERO;
				end else if ((char_s1 >= tkc_pkg::CH_ONE) && (char_s1 <= tkc_pkg::CH_NINE)) begin
					mode_n  = MODE_DEC;
					take    = 1'b1;
					take_ok = 1'b1;
					acc_mul = (acc_q << 3) + (acc_q << 1);
				end else begin
					mode_n = MODE_WORD;
				end
			end
			MODE_DEC: begin
				take    = 1'b1;
				take_ok = is_dec;
				acc_mul = (acc_q << 3) + (acc_q << 1);
			end
			MODE_ZERO: begin
				if ((char_s1 == tkc_pkg::CH_LX) || (char_s1 == tkc_pkg::CH_UX)) begin
					mode_n = MODE_HEX;
				end else begin
					mode_n  = MODE_OCT;
					take    = 1'b1;
					take_ok = is_oct;
					acc_mul = acc_q << 3;
				end
			end
			MODE_OCT: begin
				take    = 1'b1;
				take_ok = is_oct;
				acc_mul = acc_q << 3;
			end
			MODE_HEX: begin
				take    = 1'b1;
				take_ok = is_hex;
				acc_mul = acc_q << 4;
			end
			default: begin
				take = 1'b0;
			end
		endcase
		acc_n = acc_q;
		if (take && take_ok) begin
			acc_n = acc_mul + VALUE_WIDTH'(digit);
		end else if (take) begin
			bad_n = 1'b1;
		end
		pos_n = (pos_q == tkc_pkg::POS_SAT) ? tkc_pkg::POS_SAT : pos_q + 4'd1;
	end

	// keyword compare, one lane per keyword
	always_comb begin
		logic [2:0] idx;
		mask_n = mask_q;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			idx = 3'(tkc_pkg::KW_LEN[k] - 4'd1 - pos_q);
			if (!((pos_q < tkc_pkg::KW_LEN[k]) &&
			      (tkc_pkg::KW_TEXT[k][8*idx +: 8] == char_s1))) begin
				mask_n[k] = 1'b0;
			end
		end
	end

	// classification at the end of a token
	always_comb begin
		logic found;
		found   = 1'b0;
		kind_r  = tkc_pkg::KIND_IDENT;
		code_r  = '0;
		value_r = '0;
		if (mode_n == MODE_WORD) begin
			for (int k = 0; k < KEYWORD_COUNT; k++) begin
				if (!found && mask_n[k] && (tkc_pkg::KW_LEN[k] == pos_n)) begin
					found  = 1'b1;
					kind_r = tkc_pkg::KIND_KEYWORD;
					code_r = tkc_pkg::KWCODE_W'(k + 1);
				end
			end
		end else if ((mode_n == MODE_HEX) && (pos_n == 4'd2)) begin
			kind_r = tkc_pkg::KIND_EMPTYHEX;
		end else if (bad_n) begin
			kind_r = tkc_pkg::KIND_BADDIGIT;
		end else begin
			kind_r  = tkc_pkg::KIND_INT;
			value_r = tkc_pkg::LITERAL_W'(acc_n);
		end
	end

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mask_q <= '1;
			mode_q <= MODE_UNDECIDED;
			acc_q  <= '0;
			bad_q  <= 1'b0;
		end else if (finish) begin
			pos_q  <= '0;
			mask_q <= '1;
			mode_q <= MODE_UNDECIDED;
			acc_q  <= '0;
			bad_q  <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_n;
			mask_q <= mask_n;
			mode_q <= mode_n;
			acc_q  <= acc_n;
			bad_q  <= bad_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
		end else if (finish) begin
			token_valid <= 1'b1;
		end else if (!token_stall) begin
			token_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			token_kind    <= kind_r;
			keyword_code  <= code_r;
			literal_value <= value_r;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= tkc_pkg::POS_SAT)
		else $error("character position beyond saturation");

	a_clear_after_token: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (pos_q == '0) && (mode_q == MODE_UNDECIDED) && !bad_q)
		else $error("token state not cleared after last item");

	a_keyword_code: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ((token_kind == tkc_pkg::KIND_KEYWORD) == (keyword_code != '0)))
		else $error("keyword code does not agree with token kind");

	a_literal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind != tkc_pkg::KIND_INT) |-> (literal_value == '0))
		else $error("literal value set on a non-integer token");

endmodule

// File: tb/token_literal_keyword_classifier_core_tb.sv
// testbench for the token classifier: directed and random tokens checked against fixed results or a local predictor
`timescale 1ns / 1ps
module token_literal_keyword_classifier_core_tb;

	localparam int RANDOM_ITEMS   = 1820;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int KW_NUM         = 9;

	typedef enum logic [2:0] {
		MODE_UNDECIDED, MODE_WORD, MODE_DEC, MODE_ZERO, MODE_OCT, MODE_HEX
	} num_mode_t;

	typedef struct packed {
		logic [tkc_pkg::KIND_W-1:0]    kind;
		logic [tkc_pkg::KWCODE_W-1:0]  code;
		logic [tkc_pkg::LITERAL_W-1:0] value;
	} token_res_t;

	typedef struct packed {
		bit         has;
		token_res_t res;
	} fixed_res_t;

	typedef struct {
		string                         text;
		bit                            typed;
		logic [tkc_pkg::KIND_W-1:0]    kind;
		logic [tkc_pkg::KWCODE_W-1:0]  code;
		logic [tkc_pkg::LITERAL_W-1:0] value;
		int                            patch_pos;
		logic [tkc_pkg::CHAR_W-1:0]    patch_val;
	} dir_row_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          char_valid    = 1'b0;
	logic                          char_stall;
	logic [tkc_pkg::CHAR_W-1:0]    char_code     = '0;
	logic                          last_char     = 1'b0;
	logic                          token_valid;
	logic                          token_stall   = 1'b0;
	logic [tkc_pkg::KIND_W-1:0]    token_kind;
	logic [tkc_pkg::KWCODE_W-1:0]  keyword_code;
	logic [tkc_pkg::LITERAL_W-1:0] literal_value;

	string kw_names [KW_NUM] = '{
		"break", "const", "continue", "else", "if", "int", "return", "void", "while"
	};
	string letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string word_chars = "abceilnorstuvwhxABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string hex_chars  = "0123456789abcdefABCDEF";

	dir_row_t directed_rows [25] = '{
		'{"0",          1'b1, tkc_pkg::KIND_INT,      4'd0, 32'd0,         -1, 8'h00},
		'{"4294967295", 1'b1, tkc_pkg::KIND_INT,      4'd0, 32'hFFFF_FFFF, -1, 8'h00},
		'{"4294967296", 1'b1, tkc_pkg::KIND_INT,      4'd0, 32'd0,         -1, 8'h00},
		'{"0x",         1'b1, tkc_pkg::KIND_EMPTYHEX, 4'd0, 32'd0,         -1, 8'h00},
		'{"0X",         1'b1, tkc_pkg::KIND_EMPTYHEX, 4'd0, 32'd0,         -1, 8'h00},
		'{"0xFFFFFFFF", 1'b1, tkc_pkg::KIND_INT,      4'd0, 32'hFFFF_FFFF, -1, 8'h00},
		'{"0XdeadBEEF", 1'b0, tkc_pkg::KIND_INT,      4'd0, 32'd0,         -1, 8'h00},
		'{"01234567",   1'b0, tkc_pkg::KIND_INT,      4'd0, 32'd0,         -1, 8'h00},
		'{"08",         1'b1, tkc_pkg::KIND_BADDIGIT, 4'd0, 32'd0,         -1, 8'h00},
		'{"19a",        1'b1, tkc_pkg::KIND_BADDIGIT, 4'd0, 32'd0,         -1, 8'h00},
		'{"0xg",        1'b1, tkc_pkg::KIND_BADDIGIT, 4'd0, 32'd0,         -1, 8'h00},
		'{"break",      1'b1, tkc_pkg::KIND_KEYWORD,  4'd1, 32'd0,         -1, 8'h00},
		'{"const",      1'b1, tkc_pkg::KIND_KEYWORD,  4'd2, 32'd0,         -1, 8'h00},
		'{"continue",   1'b1, tkc_pkg::KIND_KEYWORD,  4'd3, 32'd0,         -1, 8'h00},
		'{"else",       1'b1, tkc_pkg::KIND_KEYWORD,  4'd4, 32'd0,         -1, 8'h00},
		'{"if",         1'b1, tkc_pkg::KIND_KEYWORD,  4'd5, 32'd0,         -1, 8'h00},
		'{"int",        1'b1, tkc_pkg::KIND_KEYWORD,  4'd6, 32'd0,         -1, 8'h00},
		'{"return",     1'b1, tkc_pkg::KIND_KEYWORD,  4'd7, 32'd0,         -1, 8'h00},
		'{"void",       1'b1, tkc_pkg::KIND_KEYWORD,  4'd8, 32'd0,         -1, 8'h00},
		'{"while",      1'b1, tkc_pkg::KIND_KEYWORD,  4'd9, 32'd0,         -1, 8'h00},
		'{"continues",  1'b1, tkc_pkg::KIND_IDENT,    4'd0, 32'd0,         -1, 8'h00},
		'{"whilewhile", 1'b1, tkc_pkg::KIND_IDENT,    4'd0, 32'd0,         -1, 8'h00},
		'{"if?",        1'b1, tkc_pkg::KIND_IDENT,    4'd0, 32'd0,          2, 8'h00},
		'{"i?",         1'b1, tkc_pkg::KIND_IDENT,    4'd0, 32'd0,          1, 8'hFF},
		'{"Int",        1'b0, tkc_pkg::KIND_INT,      4'd0, 32'd0,         -1, 8'h00}
	};

	// lexer state as the block should hold it
	logic [tkc_pkg::POS_W-1:0]     lex_pos;
	logic [KW_NUM-1:0]             lex_mask;
	num_mode_t                     lex_mode;
	logic [tkc_pkg::LITERAL_W-1:0] lex_acc;
	bit                            lex_bad;

	token_res_t                 expected_tokens [$];
	fixed_res_t                 fixed_results [$];
	logic [tkc_pkg::CHAR_W-1:0] tok_chars [$];

	bit         tok_done;
	token_res_t tok_res;
	fixed_res_t fixed_now;
	token_res_t exp_now;
	int         mismatch_count = 0;
	int         idle_cycles    = 0;
	int         burst_left     = 0;
	int         sent_items     = 0;
	int         hold_req       = 0;

	token_literal_keyword_classifier_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.last_char     (last_char),
		.token_valid   (token_valid),
		.token_stall   (token_stall),
		.token_kind    (token_kind),
		.keyword_code  (keyword_code),
		.literal_value (literal_value)
	);

	always #2 clk = ~clk;

	function automatic void lex_clear();
		lex_pos  = '0;
		lex_mask = '1;
		lex_mode = MODE_UNDECIDED;
		lex_acc  = '0;
		lex_bad  = 1'b0;
	endfunction

	function automatic int digit_of(logic [tkc_pkg::CHAR_W-1:0] c, int base);
		int d;
		if (c >= tkc_pkg::CH_ZERO && c <= tkc_pkg::CH_NINE) d = c - tkc_pkg::CH_ZERO;
		else if (c >= tkc_pkg::CH_LA && c <= tkc_pkg::CH_LF) d = c - tkc_pkg::CH_LA + 10;
		else if (c >= tkc_pkg::CH_UA && c <= tkc_pkg::CH_UF) d = c - tkc_pkg::CH_UA + 10;
		else d = base;
		return (d < base) ? d : base;
	endfunction

	function automatic void lex_char(input logic [tkc_pkg::CHAR_W-1:0] c, input bit last,
			output bit done, output token_res_t res);
		int k;
		int p;
		int d;
		int base;
		p = lex_pos;
		for (k = 0; k < KW_NUM; k++) begin
			if (!(p < kw_names[k].len() && kw_names[k][p] == c)) lex_mask[k] = 1'b0;
		end
		base = 0;
		case (lex_mode)
			MODE_UNDECIDED: begin
				if (c == tkc_pkg::CH_ZERO) begin
					lex_mode = MODE_ZERO;
				end else if (c >= tkc_pkg::CH_ONE && c <= tkc_pkg::CH_NINE) begin
					lex_mode = MODE_DEC;
					lex_acc  = tkc_pkg::LITERAL_W'(c - tkc_pkg::CH_ZERO);
				end else begin
					lex_mode = MODE_WORD;
				end
			end
			MODE_DEC: base = 10;
			MODE_ZERO: begin
				if (c == tkc_pkg::CH_LX || c == tkc_pkg::CH_UX) begin
					lex_mode = MODE_HEX;
				end else begin
					lex_mode = MODE_OCT;
					base     = 8;
				end
			end
			MODE_OCT: base = 8;
			MODE_HEX: base = 16;
			default: ;
		endcase
		if (base != 0) begin
			d = digit_of(c, base);
			if (d >= base) lex_bad = 1'b1;
			else lex_acc = lex_acc * tkc_pkg::LITERAL_W'(base) + tkc_pkg::LITERAL_W'(d);
		end
		if (lex_pos < tkc_pkg::POS_SAT) lex_pos = lex_pos + 1'b1;
		done = last;
		res  = '0;
		if (last) begin
			if (lex_mode == MODE_WORD) begin
				res.kind = tkc_pkg::KIND_IDENT;
				// walk down so the lowest matching code wins
				for (k = KW_NUM - 1; k >= 0; k--) begin
					if (lex_mask[k] && kw_names[k].len() == lex_pos) begin
						res.kind = tkc_pkg::KIND_KEYWORD;
						res.code = tkc_pkg::KWCODE_W'(k + 1);
					end
				end
			end else if (lex_mode == MODE_HEX && lex_pos == 2) begin
				res.kind = tkc_pkg::KIND_EMPTYHEX;
			end else if (lex_bad) begin
				res.kind = tkc_pkg::KIND_BADDIGIT;
			end else begin
				res.kind  = tkc_pkg::KIND_INT;
				res.value = lex_acc;
			end
			lex_clear();
		end
	endfunction

	function automatic logic [tkc_pkg::CHAR_W-1:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic void push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) tok_chars.push_back(s[i]);
	endfunction

	function automatic void make_token();
		int cat;
		int len;
		int i;
		tok_chars.delete();
		cat = $urandom_range(0, 99);
		if (cat < 25) begin
			push_text(kw_names[$urandom_range(0, KW_NUM - 1)]);
			// near misses: cut short, one too many, one character swapped
			if (cat >= 15) begin
				case ($urandom_range(0, 2))
					0: void'(tok_chars.pop_back());
					1: tok_chars.push_back(pick(word_chars));
					default: tok_chars[$urandom_range(0, tok_chars.size() - 1)] = pick(word_chars);
				endcase
			end
		end else if (cat < 40) begin
			tok_chars.push_back(pick(letters));
			len = $urandom_range(0, 11);
			for (i = 0; i < len; i++) tok_chars.push_back(pick(word_chars));
		end else if (cat < 90) begin
			case (cat % 3)
				0: begin
					if ($urandom_range(0, 2) == 0) begin
						push_text($sformatf("%0d", $urandom));
					end else begin
						tok_chars.push_back(tkc_pkg::CH_ONE +
							tkc_pkg::CHAR_W'($urandom_range(0, 8)));
						len = $urandom_range(0, 11);
						for (i = 0; i < len; i++) tok_chars.push_back(tkc_pkg::CH_ZERO +
							tkc_pkg::CHAR_W'($urandom_range(0, 9)));
					end
				end
				1: begin
					tok_chars.push_back(tkc_pkg::CH_ZERO);
					len = $urandom_range(0, 12);
					for (i = 0; i < len; i++) tok_chars.push_back(tkc_pkg::CH_ZERO +
						tkc_pkg::CHAR_W'($urandom_range(0, 7)));
				end
				default: begin
					tok_chars.push_back(tkc_pkg::CH_ZERO);
					tok_chars.push_back($urandom_range(0, 1) ? tkc_pkg::CH_LX : tkc_pkg::CH_UX);
					len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
					for (i = 0; i < len; i++) tok_chars.push_back(pick(hex_chars));
				end
			endcase
			// corrupt one character after the first, or append one if there is only one
			if (cat >= 75) begin
				if (tok_chars.size() > 1) begin
					tok_chars[$urandom_range(1, tok_chars.size() - 1)] =
						tkc_pkg::CHAR_W'($urandom_range(0, 255));
				end else begin
					tok_chars.push_back(tkc_pkg::CHAR_W'($urandom_range(0, 255)));
				end
			end
		end else begin
			len = $urandom_range(1, 10);
			for (i = 0; i < len; i++) tok_chars.push_back(tkc_pkg::CHAR_W'($urandom_range(0, 255)));
		end
	endfunction

	task automatic send_char(input logic [tkc_pkg::CHAR_W-1:0] c, input bit last);
		if (burst_left == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
		end
		burst_left--;
		char_valid <= 1'b1;
		char_code  <= c;
		last_char  <= last;
		do @(posedge clk); while (char_stall);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_token(input bit has_fixed, input token_res_t fixed_val);
		int i;
		fixed_results.push_back('{has_fixed, fixed_val});
		for (i = 0; i < tok_chars.size(); i++) send_char(tok_chars[i], i == tok_chars.size() - 1);
	endtask

	// predict on every accepted item
	always @(posedge clk) begin
		if (!arst_n) begin
			lex_clear();
		end else if (char_valid && !char_stall) begin
			lex_char(char_code, last_char, tok_done, tok_res);
			if (tok_done) begin
				fixed_now = fixed_results.pop_front();
				expected_tokens.push_back(fixed_now.has ? fixed_now.res : tok_res);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t unexpected token: kind %0d code %0d value %h", $time,
					token_kind, keyword_code, literal_value);
				mismatch_count++;
			end else begin
				exp_now = expected_tokens.pop_front();
				if (token_kind !== exp_now.kind) begin
					$display("%0t token_kind: expected %0d, actual %0d", $time, exp_now.kind, token_kind);
					mismatch_count++;
				end
				if (keyword_code !== exp_now.code) begin
					$display("%0t keyword_code: expected %0d, actual %0d", $time, exp_now.code,
						keyword_code);
					mismatch_count++;
				end
				if (literal_value !== exp_now.value) begin
					$display("%0t literal_value: expected %h, actual %h", $time, exp_now.value,
						literal_value);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (token_valid && !token_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : receiver
		int phase_left;
		int pattern;
		int holds_done;
		phase_left = 0;
		pattern    = 0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				token_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (phase_left == 0) begin
					pattern    = $urandom_range(0, 2);
					phase_left = $urandom_range(5, 60);
				end
				phase_left--;
				case (pattern)
					0: token_stall <= 1'b0;
					1: token_stall <= ($urandom_range(0, 3) == 0);
					default: token_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int r;
		int n;
		int tokens;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (r = 0; r < $size(directed_rows); r++) begin
			tok_chars.delete();
			push_text(directed_rows[r].text);
			n = directed_rows[r].patch_pos;
			if (n >= 0) tok_chars[n] = directed_rows[r].patch_val;
			send_token(directed_rows[r].typed,
				{directed_rows[r].kind, directed_rows[r].code, directed_rows[r].value});
		end
		tokens = 0;
		n = sent_items;
		while (sent_items - n < RANDOM_ITEMS) begin
			// long receiver hold-off while characters keep coming
			if (tokens == 40 || tokens == 300) hold_req++;
			make_token();
			send_token(1'b0, '0);
			tokens++;
		end
		char_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
src/tkc_pkg.sv
src/token_literal_keyword_classifier_core.sv
tb/token_literal_keyword_classifier_core_tb.sv
